/* design/indexed_shift_list_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the indexed shift list.
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef INDEXED_SHIFT_LIST_TOP_ASSERT_SVH
`define INDEXED_SHIFT_LIST_TOP_ASSERT_SVH

// Same-cycle implication, switched off while rst is high.
`define ISL_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// Next-cycle implication, switched off while rst is high.
`define ISL_ASSERT_NXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`endif

/* design/isl_pkg.sv */
// ----------------------------------------------------------------------------
// isl_pkg
// Shared types, codes and sizes of the indexed shift list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package isl_pkg;

   localparam int ISL_CAPACITY   = 32;
   localparam int ISL_DATA_WIDTH = 32;

   // Fixed field widths of the stream words.
   localparam int ISL_OP_W     = 2;
   localparam int ISL_POS_W    = 6;
   localparam int ISL_VALUE_W  = 32;
   localparam int ISL_STATUS_W = 2;
   localparam int ISL_COUNT_W  = 6;
   localparam int ISL_REQ_W    = 40;
   localparam int ISL_RSP_W    = 40;

   // Widest entry and widest cell index the parameter ranges allow.
   localparam int ISL_MAXW  = 64;
   localparam int ISL_TGT_W = 8;

   localparam logic [ISL_OP_W-1:0] OP_READ   = 2'd0;
   localparam logic [ISL_OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [ISL_OP_W-1:0] OP_DELETE = 2'd2;
   localparam logic [ISL_OP_W-1:0] OP_APPEND = 2'd3;

   localparam logic [ISL_STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [ISL_STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [ISL_STATUS_W-1:0] ST_FULL  = 2'd2;

   // Command broadcast from the decoder to every cell of the chain.
   typedef struct packed {
      logic                 read;
      logic                 shift_up;
      logic                 shift_down;
      logic                 write;
      logic [ISL_TGT_W-1:0] target;
      logic [ISL_MAXW-1:0]  value;
   } isl_cmd_type;

endpackage

`default_nettype wire

/* design/isl_cell.sv */
// ----------------------------------------------------------------------------
// isl_cell
// One list slot: holds an entry and moves it to or from its neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isl_cell
   import isl_pkg::*;
#(
   parameter int DATA_WIDTH = ISL_DATA_WIDTH,
   parameter int INDEX      = 0
) (
   input  wire logic                  clock,
   input  wire isl_cmd_type           cmd,
   input  wire logic [DATA_WIDTH-1:0] left_data,
   input  wire logic [DATA_WIDTH-1:0] right_data,
   output logic      [DATA_WIDTH-1:0] data_out,
   output logic      [DATA_WIDTH-1:0] hit_data
);

   localparam logic [ISL_TGT_W-1:0] MY_IDX = ISL_TGT_W'(INDEX);

   logic [DATA_WIDTH-1:0] entry_ff;
   logic [DATA_WIDTH-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.shift_up) begin
         if (MY_IDX > cmd.target) begin
            entry_in = left_data;
         end else if (MY_IDX == cmd.target) begin
            entry_in = cmd.value[DATA_WIDTH-1:0];
         end
      end else if (cmd.shift_down) begin
         if (MY_IDX >= cmd.target) begin
            entry_in = right_data;
         end
      end else if (cmd.write) begin
         if (MY_IDX == cmd.target) begin
            entry_in = cmd.value[DATA_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign data_out = entry_ff;
   assign hit_data = (cmd.read && (MY_IDX == cmd.target)) ? entry_ff : '0;

endmodule

`default_nettype wire

/* design/isl_decode.sv */
// ----------------------------------------------------------------------------
// isl_decode
// Checks an operation against the count and builds the cell command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isl_decode
   import isl_pkg::*;
#(
   parameter int CAPACITY = ISL_CAPACITY,
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input  wire logic                    fire,
   input  wire logic [ISL_OP_W-1:0]     op,
   input  wire logic [ISL_POS_W-1:0]    position,
   input  wire logic [ISL_VALUE_W-1:0]  value,
   input  wire logic [CNT_W-1:0]        count,
   output logic      [CNT_W-1:0]        count_next,
   output logic      [ISL_STATUS_W-1:0] status,
   output isl_cmd_type                  cmd
);

   localparam int CMP_W = (CNT_W > ISL_POS_W) ? CNT_W : ISL_POS_W;

   logic [CMP_W-1:0] pos_cmp;
   logic [CMP_W-1:0] cnt_cmp;
   logic             full;

   assign pos_cmp = CMP_W'(position);
   assign cnt_cmp = CMP_W'(count);
   assign full    = (count == CNT_W'(CAPACITY));

   always_comb begin
      status         = ST_OK;
      count_next     = count;
      cmd            = '0;
      cmd.value      = ISL_MAXW'(value);
      cmd.target     = ISL_TGT_W'(position);
      case (op)
         OP_READ: begin
            if (pos_cmp >= cnt_cmp) begin
               status = ST_RANGE;
            end else begin
               cmd.read = fire;
            end
         end
         OP_INSERT: begin
            // The index is judged before the free space.
            if (pos_cmp > cnt_cmp) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               cmd.shift_up = fire;
               if (fire) begin
                  count_next = count + CNT_W'(1);
               end
            end
         end
         OP_DELETE: begin
            if (pos_cmp >= cnt_cmp) begin
               status = ST_RANGE;
            end else begin
               cmd.shift_down = fire;
               if (fire) begin
                  count_next = count - CNT_W'(1);
               end
            end
         end
         OP_APPEND: begin
            cmd.target = ISL_TGT_W'(count);
            if (full) begin
               status = ST_FULL;
            end else begin
               cmd.write = fire;
               if (fire) begin
                  count_next = count + CNT_W'(1);
               end
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

endmodule

`default_nettype wire

/* design/indexed_shift_list_top.sv */
// ----------------------------------------------------------------------------
// indexed_shift_list_top
// Ordered list of words with read, insert, delete and append at an index.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req_    | in  | tdata: op[1:0], position[7:2], value[39:8]
//  rsp_    | out | tdata: status[1:0], read_value[33:2], entry_count[39:34]
//
// One word is taken per cycle while the response is not stalled; its response
// is registered and shows in the cycle after acceptance. All slots of the cell
// chain shift together, so no operation takes longer than another.
// A stalled response holds the output register, and a new word is taken only
// when that register is empty or being drained in the same cycle.
// Reset clears the entry count and the response valid; slot contents are not
// cleared, as no slot at or beyond the count is ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module indexed_shift_list_top
   import isl_pkg::*;
#(
   parameter int CAPACITY   = ISL_CAPACITY,
   parameter int DATA_WIDTH = ISL_DATA_WIDTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [ISL_REQ_W-1:0] req_tdata,  // op, position, value
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic      [ISL_RSP_W-1:0] rsp_tdata   // status, read_value, entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic                    fire;
   logic [ISL_OP_W-1:0]     req_op;
   logic [ISL_POS_W-1:0]    req_position;
   logic [ISL_VALUE_W-1:0]  req_value;

   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic [ISL_STATUS_W-1:0] status;
   isl_cmd_type             cmd;

   logic [DATA_WIDTH-1:0]   cell_data [CAPACITY];
   logic [DATA_WIDTH-1:0]   hit_data  [CAPACITY];
   logic [DATA_WIDTH-1:0]   read_any;
   logic [ISL_MAXW-1:0]     read_wide;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [ISL_RSP_W-1:0]    rsp_data_ff;
   logic [ISL_RSP_W-1:0]    rsp_data_in;

   assign req_op       = req_tdata[1:0];
   assign req_position = req_tdata[7:2];
   assign req_value    = req_tdata[39:8];

   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign fire       = req_tvalid && req_tready;

   isl_decode #(
      .CAPACITY (CAPACITY)
   ) u_isl_decode (
      .fire       (fire),
      .op         (req_op),
      .position   (req_position),
      .value      (req_value),
      .count      (count_ff),
      .count_next (count_in),
      .status     (status),
      .cmd        (cmd)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      // The chain ends feed back their own slot, which only ever leaves that slot unchanged.
      isl_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .INDEX      (i)
      ) u_isl_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_data  (cell_data[(i == 0) ? 0 : i - 1]),
         .right_data (cell_data[(i == CAPACITY - 1) ? i : i + 1]),
         .data_out   (cell_data[i]),
         .hit_data   (hit_data[i])
      );
   end

   // At most one cell reports a hit, so the read is an OR over all slots.
   always_comb begin
      read_any = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_any = read_any | hit_data[i];
      end
   end

   assign read_wide = ISL_MAXW'(read_any);

   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_tready);
   assign rsp_data_in  = {ISL_COUNT_W'(count_in), read_wide[ISL_VALUE_W-1:0], status};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

/* design/isl_checker.sv */
// ----------------------------------------------------------------------------
// isl_checker
// Port-level checks of the indexed shift list, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_shift_list_top_assert.svh"

module isl_checker
   import isl_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_tvalid,
   input wire logic                 req_tready,
   input wire logic                 rsp_tvalid,
   input wire logic                 rsp_tready,
   input wire logic [ISL_RSP_W-1:0] rsp_tdata   // status, read_value, entry_count
);

   logic req_fire;
   logic rsp_stall;
   logic rsp_failed;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_failed = rsp_tvalid && (rsp_tdata[1:0] != ST_OK);

   // Every accepted word yields a response word in the next cycle.
   `ISL_ASSERT_NXT(a_req_gives_rsp, clock, reset, req_fire, rsp_tvalid)

   // A held response keeps its contents.
   `ISL_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // A failed operation never returns read data, and the status is a known code.
   `ISL_ASSERT_IMP(a_fail_no_data, clock, reset, rsp_failed,
      (rsp_tdata[33:2] == '0) && (rsp_tdata[1:0] != 2'd3))

   // Reset always leaves the response channel empty.
   `ISL_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind indexed_shift_list_top isl_checker u_isl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
